// ===== hw/rtl/bbip_pkg.sv =====
// package for the bit-plane binary inner product core
// holds sizes, reset values, register and mode codes, the per-word control struct and the count vector type
// no dependencies
`default_nettype none

package bbip_pkg;

    localparam int DIM       = 128;
    localparam int MAX_QBITS = 8;
    localparam int WORD_W    = 64;
    localparam int WORDS_MAX = DIM / WORD_W;
    localparam int GRP_W     = (WORDS_MAX > 1) ? $clog2(WORDS_MAX) : 1;
    localparam int BIT_IDX_W = $clog2(WORD_W);
    localparam int CNT_W     = $clog2(WORD_W) + 1;
    localparam int POS_W     = $clog2(DIM);
    localparam int LIMIT_W   = POS_W + 1;
    localparam int QB_W      = 4;
    localparam int WC_W      = 2;
    localparam int CMP_W     = GRP_W + WC_W + 1;
    localparam int QV_W      = 8;
    localparam int ACC_W     = 15;
    localparam int CEN_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 4;

    localparam logic [QB_W-1:0] QUERY_BITS_RST = QB_W'(4);
    localparam logic [WC_W-1:0] WORD_COUNT_RST = WC_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUERY_BITS = 1'b0,
        REG_WORD_COUNT = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_WORD = 1'b1
    } t_mode;

    // control that travels with one data word down the pipeline
    typedef struct packed {
        logic             first;
        logic             last;
        logic [ACC_W-1:0] qtotal;
    } t_word_ctl;

    typedef logic [MAX_QBITS-1:0][CNT_W-1:0] t_count_vec;

endpackage

`default_nettype wire

// ===== hw/rtl/bbip_lane.sv =====
// one bit-plane lane: plane word storage, AND with the data word, popcount
// uses bbip_pkg
`default_nettype none

module bbip_lane (
    input  wire logic                           i_clk,
    input  wire logic                           i_wr_en,
    input  wire logic [bbip_pkg::GRP_W-1:0]     i_wr_grp,
    input  wire logic [bbip_pkg::BIT_IDX_W-1:0] i_wr_sel,
    input  wire logic                           i_wr_bit,
    input  wire logic [bbip_pkg::GRP_W-1:0]     i_rd_grp,
    input  wire logic [bbip_pkg::WORD_W-1:0]    i_data_word,
    input  wire logic                           i_cap_en,
    output logic      [bbip_pkg::CNT_W-1:0]     o_count
);
    import bbip_pkg::*;

    logic [WORD_W-1:0] r_plane [WORDS_MAX];
    logic [WORD_W-1:0] masked;
    logic [1:0]        l1 [32];
    logic [2:0]        l2 [16];
    logic [3:0]        l3 [8];
    logic [4:0]        l4 [4];
    logic [5:0]        l5 [2];
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_plane[i_wr_grp][i_wr_sel] <= i_wr_bit;
        end
    end

    assign masked = i_data_word & r_plane[i_rd_grp];

    // popcount adder tree
    always_comb begin
        for (int k = 0; k < 32; k++) l1[k] = {1'b0, masked[2*k]} + {1'b0, masked[2*k+1]};
        for (int k = 0; k < 16; k++) l2[k] = {1'b0, l1[2*k]} + {1'b0, l1[2*k+1]};
        for (int k = 0; k < 8; k++)  l3[k] = {1'b0, l2[2*k]} + {1'b0, l2[2*k+1]};
        for (int k = 0; k < 4; k++)  l4[k] = {1'b0, l3[2*k]} + {1'b0, l3[2*k+1]};
        for (int k = 0; k < 2; k++)  l5[k] = {1'b0, l4[2*k]} + {1'b0, l4[2*k+1]};
        n_count = {1'b0, l5[0]} + {1'b0, l5[1]};
    end

    always_ff @(posedge i_clk) begin
        if (i_cap_en) begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== hw/rtl/bbip_merge.sv =====
// merging stage: weights each lane popcount by two to the power of its plane index and sums them
// uses bbip_pkg
`default_nettype none

module bbip_merge (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire bbip_pkg::t_count_vec    i_counts,
    input  wire bbip_pkg::t_word_ctl     i_ctl,
    output logic [bbip_pkg::ACC_W-1:0]   o_sum,
    output bbip_pkg::t_word_ctl          o_ctl
);
    import bbip_pkg::*;

    logic [ACC_W-1:0] n_sum;
    logic [ACC_W-1:0] r_sum;
    t_word_ctl        r_ctl;

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < MAX_QBITS; i++) begin
            n_sum = n_sum + (ACC_W'(i_counts[i]) << i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
            r_ctl <= i_ctl;
        end
    end

    assign o_sum = r_sum;
    assign o_ctl = r_ctl;

endmodule

`default_nettype wire

// ===== hw/rtl/bitplane_binary_inner_product_core.sv =====
// top level of the bit-plane binary inner product core
// uses bbip_pkg, bbip_lane and bbip_merge
`default_nettype none

// Query values are loaded one per transfer (mode 0) and spread over
// MAX_QBITS plane lanes; data code words (mode 1) then stream at one word per
// cycle while the input is not stalled, each lane ANDing the word with its
// plane and popcounting it in the accept cycle. The merging stage then weights
// and sums the registered lane counts, and the accumulator and output register
// follow; a vector's result is valid once its last word has passed the lane,
// merging and output registers. The sustained rate of one item per clock is set
// by the 64-bit popcount in each lane and by the eight-term weighted sum in the
// merging stage. A held result stalls the input only when a further finished
// result reaches the merging stage behind it and a word waits in the lane
// registers. query_bits and word_count may only be written while the core is
// idle; query planes that were never loaded read as undefined.
module bitplane_binary_inner_product_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [bbip_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bbip_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_mode,
    input  wire logic [bbip_pkg::QV_W-1:0]         i_query_value,
    input  wire logic [bbip_pkg::WORD_W-1:0]       i_data_word,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [bbip_pkg::ACC_W-1:0]        o_inner_product,
    output logic signed [bbip_pkg::CEN_W-1:0]      o_centered_product
);
    import bbip_pkg::*;

    logic [QB_W-1:0]   r_query_bits;
    logic [WC_W-1:0]   r_word_count;
    logic [POS_W-1:0]  r_load_pos;
    logic [GRP_W-1:0]  r_word_pos;
    logic [ACC_W-1:0]  r_qtotal;
    logic [ACC_W-1:0]  r_acc;
    logic              r_a_valid;
    t_word_ctl         r_a_ctl;
    logic              r_b_valid;
    logic              r_out_valid;
    logic [ACC_W-1:0]  r_inner;
    logic [CEN_W-1:0]  r_centered;

    logic [QB_W-1:0]    planes;
    logic [WC_W-1:0]    words;
    logic [LIMIT_W-1:0] limit;
    logic [POS_W-1:0]   pos;
    logic [LIMIT_W-1:0] pos_inc;
    logic [POS_W-1:0]   n_load_pos;
    logic [ACC_W-1:0]   n_qtotal;
    logic [GRP_W-1:0]   wp;
    logic [CMP_W-1:0]   wp_inc;
    logic               word_last;
    t_word_ctl          n_a_ctl;
    logic [MAX_QBITS-1:0] plane_bit;

    logic               in_fire;
    logic               load_fire;
    logic               word_fire;
    logic               out_free;
    logic               b_move;
    logic               b_ready;
    logic               a_move;

    t_count_vec         counts;
    logic [ACC_W-1:0]   b_sum;
    t_word_ctl          b_ctl;
    logic [ACC_W-1:0]   n_acc;
    logic [CEN_W-1:0]   n_centered;

    // handshake and pipeline flow
    assign out_free   = !r_out_valid || i_out_ready;
    assign b_move     = r_b_valid && (!b_ctl.last || out_free);
    assign b_ready    = !r_b_valid || b_move;
    assign a_move     = r_a_valid && b_ready;
    assign o_in_ready = !r_a_valid || b_ready;
    assign in_fire    = i_in_valid && o_in_ready;
    assign load_fire  = in_fire && (i_mode == MODE_LOAD);
    assign word_fire  = in_fire && (i_mode == MODE_WORD);

    // clamp register values into their legal ranges
    always_comb begin
        if (r_query_bits == '0) begin
            planes = QB_W'(1);
        end else if (r_query_bits > QB_W'(MAX_QBITS)) begin
            planes = QB_W'(MAX_QBITS);
        end else begin
            planes = r_query_bits;
        end
        if (r_word_count == '0) begin
            words = WC_W'(1);
        end else if (CMP_W'(r_word_count) > CMP_W'(WORDS_MAX)) begin
            words = WC_W'(WORDS_MAX);
        end else begin
            words = r_word_count;
        end
    end

    // query load position and running query sum
    always_comb begin
        limit      = LIMIT_W'(words) << BIT_IDX_W;
        pos        = (LIMIT_W'(r_load_pos) < limit) ? r_load_pos : '0;
        pos_inc    = LIMIT_W'(pos) + LIMIT_W'(1);
        n_load_pos = (pos_inc >= limit) ? '0 : POS_W'(pos_inc);
        n_qtotal   = (pos == '0) ? ACC_W'(i_query_value)
                                 : r_qtotal + ACC_W'(i_query_value);
    end

    // data word position within the vector
    // a stale position clamps to word 0 but keeps the partial sum
    always_comb begin
        wp        = (CMP_W'(r_word_pos) < CMP_W'(words)) ? r_word_pos : '0;
        wp_inc    = CMP_W'(wp) + CMP_W'(1);
        word_last = (wp_inc >= CMP_W'(words));
        n_a_ctl.first  = (r_word_pos == '0);
        n_a_ctl.last   = word_last;
        n_a_ctl.qtotal = r_qtotal;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_bits <= QUERY_BITS_RST;
            r_word_count <= WORD_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_QUERY_BITS: r_query_bits <= i_cfg_data[QB_W-1:0];
                REG_WORD_COUNT: r_word_count <= i_cfg_data[WC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos <= '0;
            r_word_pos <= '0;
            r_qtotal   <= '0;
        end else if (load_fire) begin
            r_load_pos <= n_load_pos;
            r_word_pos <= '0;
            r_qtotal   <= n_qtotal;
        end else if (word_fire) begin
            r_word_pos <= word_last ? '0 : GRP_W'(wp_inc);
        end
    end

    // plane lanes
    for (genvar g = 0; g < MAX_QBITS; g++) begin : g_lane
        assign plane_bit[g] = i_query_value[g] && (QB_W'(g) < planes);

        bbip_lane u_lane (
            .i_clk       (i_clk),
            .i_wr_en     (load_fire),
            .i_wr_grp    (GRP_W'(pos >> BIT_IDX_W)),
            .i_wr_sel    (~pos[BIT_IDX_W-1:0]),
            .i_wr_bit    (plane_bit[g]),
            .i_rd_grp    (wp),
            .i_data_word (i_data_word),
            .i_cap_en    (word_fire),
            .o_count     (counts[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_a_valid <= word_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (word_fire) begin
            r_a_ctl <= n_a_ctl;
        end
    end

    bbip_merge u_merge (
        .i_clk    (i_clk),
        .i_en     (a_move),
        .i_counts (counts),
        .i_ctl    (r_a_ctl),
        .o_sum    (b_sum),
        .o_ctl    (b_ctl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    // accumulate and form the result
    always_comb begin
        n_acc      = (b_ctl.first ? '0 : r_acc) + b_sum;
        n_centered = CEN_W'({n_acc, 1'b0}) - CEN_W'(b_ctl.qtotal);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (b_move) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_move && b_ctl.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move && b_ctl.last) begin
            r_inner    <= n_acc;
            r_centered <= n_centered;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_inner_product    = r_inner;
    assign o_centered_product = signed'(r_centered);

`ifndef ASSERT_OFF
    // input stalls only when every stage holds an item behind a waiting result
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_a_valid && r_b_valid && r_out_valid))
        else $error("input stalled with a free pipeline stage");

    // a result appears only from a finished vector in the merging stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_b_valid && b_ctl.last))
        else $error("result without a finished vector");

    // query loads never enter the word pipeline
    a_load_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_fire |=> !r_a_valid)
        else $error("query load entered the word pipeline");
`endif

endmodule

`default_nettype wire
